@@ src/stp_pkg.sv @@
// shared types, widths and constants of the timed stepper positioner
`timescale 1ns / 1ps

package stp_pkg;

    localparam int MOTORS_DEF = 4;

    localparam int MOTOR_W = 2;
    localparam int POS_W   = 15;
    localparam int TIME_W  = 16;
    localparam int REV_W   = 15;
    localparam int FS_W    = 16;
    localparam int CD_W    = 18;
    localparam int PER_W   = 17;
    localparam int MASK_W  = 4;
    localparam int REVS    = 4;

    // divider: dividend is move_time * 10, divisor is the step distance
    localparam int DIVD_W = 20;
    localparam int DIVS_W = 16;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEPS_REV_ZERO  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEPS_REV_ONE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEPS_REV_TWO   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEPS_REV_THREE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTINUOUS_MASK = 3'd4;

    localparam logic [REV_W-1:0] REV_RESET  = 15'd200;
    localparam logic [POS_W-1:0] PERIOD_MIN = 15'd300;
    localparam logic [POS_W-1:0] PERIOD_MAX = 15'd32760;
    localparam logic [FS_W-1:0]  REV_FULL   = 16'd32768;

    typedef struct packed {
        logic              mode;
        logic [MOTOR_W-1:0] motor;
        logic [TIME_W-1:0]  elapsed;
        logic [POS_W-1:0]   target_position;
        logic [TIME_W-1:0]  move_time;
    } cmd_item_t;

    typedef struct packed {
        logic              step_pulse;
        logic              direction;
        logic [MOTOR_W-1:0] motor_echo;
        logic [POS_W-1:0]   position;
        logic              moving;
    } rsp_item_t;

    typedef struct packed {
        logic signed [CD_W-1:0]  countdown;
        logic signed [PER_W-1:0] step_period;
        logic [POS_W-1:0]        target;
        logic [POS_W-1:0]        position;
    } motor_state_t;

    localparam int STATE_W = $bits(motor_state_t);

endpackage

@@ src/stp_ram.sv @@
// generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps

module stp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/stp_div.sv @@
// bit-serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module stp_div
    import stp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIVD_W-1:0] dividend,
    input  logic [DIVS_W-1:0] divisor,
    output logic [DIVD_W-1:0] quotient,
    output logic              done
);

    localparam int CNT_W = $clog2(DIVD_W + 1);
    localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(DIVD_W);

    logic [DIVS_W-1:0] rem_reg, rem_next;
    logic [DIVD_W-1:0] quo_reg, quo_next;
    logic [DIVS_W-1:0] dsr_reg, dsr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [DIVS_W:0]   shifted;
    logic [DIVS_W+1:0] diff;

    // dividend bits shift out of the top of quo_reg into the remainder
    assign shifted = {rem_reg, quo_reg[DIVD_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dsr_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = CNT_LOAD;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[DIVS_W+1])
            begin
                rem_next = diff[DIVS_W-1:0];
                quo_next = {quo_reg[DIVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DIVS_W-1:0];
                quo_next = {quo_reg[DIVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

@@ src/stepper_timed_positioner_top.sv @@
// top level of the timed stepper positioner: sequencer, motor state store, output register
//
// usage:
//   cmd channel (cmd_valid / cmd_stall / cmd_data) carries one item: a tick with the
//   elapsed time for one motor, or a set-move with a target position and move time.
//   every item gives exactly one result on the rsp channel (rsp_valid / rsp_stall /
//   rsp_data): step pulse, direction, motor, position and moving flag.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes steps per
//   revolution of each motor and the continuous-rotation mask; cfg_ready is always high,
//   writes belong in idle periods only.
// sequence: S_LOAD, then S_FIN for a tick or an out-of-range motor; a set-move passes
//   S_PREP, then S_GO if its distance is nonzero; one that computes a new period waits
//   in S_DIV while the bit-serial divider retires one quotient bit of 20 per cycle.
// throughput: one item at a time; the next item is taken in the cycle after the result
//   is loaded into the output register.
// reset clears all motors to idle at position zero (per-motor valid bits, no sweep),
//   steps per revolution to 200 and the continuous mask to zero.
// a stalled result holds in the output register; one more item can be taken and worked
//   on meanwhile, and it waits in its last step until the register frees up.
`timescale 1ns / 1ps

module stepper_timed_positioner_top
    import stp_pkg::*;
#(
    parameter int MOTORS = MOTORS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  cmd_item_t            cmd_data,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output rsp_item_t            rsp_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REV_W-1:0]     cfg_data
);

    localparam int AW = (MOTORS > 1) ? $clog2(MOTORS) : 1;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_LOAD = 6'b000010,
        S_PREP = 6'b000100,
        S_GO   = 6'b001000,
        S_DIV  = 6'b010000,
        S_FIN  = 6'b100000
    } seq_state_t;

    seq_state_t state_reg, state_next;

    logic [REV_W-1:0]  steps_rev_reg [REVS];
    logic [MASK_W-1:0] cont_mask_reg;
    logic [MOTORS-1:0] vld_reg;

    cmd_item_t    item_reg, item_next;
    motor_state_t cur_reg, cur_next;
    logic [FS_W-1:0]         fs_reg, fs_next;
    logic [FS_W+2:0]         fs5_reg, fs5_next;
    logic signed [PER_W-1:0] dv_reg, dv_next;
    logic signed [CD_W-1:0]  cd_sub_reg, cd_sub_next;
    logic signed [PER_W-1:0] adv_reg, adv_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    rsp_item_t               rsp_data_reg;

    logic                  cmd_acc;
    logic                  in_range;
    logic [AW-1:0]         addr;
    logic [STATE_W-1:0]    ram_rdata;
    motor_state_t          st_raw;
    logic                  ram_we;
    logic                  rsp_load;

    logic [REV_W-1:0]        rev_sel;
    logic [FS_W-1:0]         fs_w;
    logic [PER_W-1:0]        dv_mag;
    logic [FS_W+2:0]         mag6;
    logic                    far;
    logic signed [CD_W-1:0]  dv_ext;
    logic signed [CD_W-1:0]  fs_ext;
    logic signed [CD_W-1:0]  adv18;
    logic [PER_W-1:0]        adv_mag;
    logic [DIVD_W-1:0]       mt10;
    logic                    div_start;
    logic [DIVD_W-1:0]       div_quo;
    logic                    div_done;

    logic [POS_W-1:0]        mag;
    logic signed [PER_W-1:0] new_period;
    logic [PER_W-1:0]        per_abs;
    logic                    cd_le0;
    logic [FS_W-1:0]         pinc;
    logic [FS_W-1:0]         fsm1;
    logic [POS_W-1:0]        stepped_pos;
    logic                    per_fwd;
    motor_state_t            new_state;
    rsp_item_t               rsp_w;

    assign cmd_stall = (state_reg != S_IDLE);
    assign cmd_acc   = cmd_valid && !cmd_stall;
    assign cfg_ready = 1'b1;
    assign in_range  = (int'(item_reg.motor) < MOTORS);
    assign addr      = AW'(item_reg.motor);

    stp_ram #(
        .WIDTH (STATE_W),
        .DEPTH (MOTORS)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr),
        .wdata (new_state),
        .re    (cmd_acc),
        .raddr (AW'(cmd_data.motor)),
        .rdata (ram_rdata)
    );

    // a motor never written since reset reads as idle at position zero
    assign st_raw = (in_range && vld_reg[addr]) ? motor_state_t'(ram_rdata) : '0;

    assign rev_sel = steps_rev_reg[item_reg.motor];
    assign fs_w    = (rev_sel == '0) ? REV_FULL : {1'b0, rev_sel};

    // shortest-way adjustment for continuous motors
    assign dv_mag = dv_reg[PER_W-1] ? PER_W'(-dv_reg) : PER_W'(dv_reg);
    assign mag6   = {dv_mag, 2'b00} + (FS_W+3)'({dv_mag, 1'b0});
    assign far    = cont_mask_reg[item_reg.motor] && (mag6 > fs5_reg) && (dv_reg != '0);
    assign dv_ext = {dv_reg[PER_W-1], dv_reg};
    assign fs_ext = $signed({2'b00, fs_reg});
    assign adv18  = !far ? dv_ext : (dv_reg[PER_W-1] ? dv_ext + fs_ext : dv_ext - fs_ext);

    assign adv_mag = adv_reg[PER_W-1] ? PER_W'(-adv_reg) : PER_W'(adv_reg);
    assign mt10    = DIVD_W'({item_reg.move_time, 3'b000})
                   + DIVD_W'({item_reg.move_time, 1'b0});

    stp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mt10),
        .divisor  (adv_mag[DIVS_W-1:0]),
        .quotient (div_quo),
        .done     (div_done)
    );

    always_comb
    begin
        state_next  = state_reg;
        item_next   = item_reg;
        cur_next    = cur_reg;
        fs_next     = fs_reg;
        fs5_next    = fs5_reg;
        dv_next     = dv_reg;
        cd_sub_next = cd_sub_reg;
        adv_next    = adv_reg;
        div_start   = 1'b0;
        ram_we      = 1'b0;
        rsp_load    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_acc)
                begin
                    item_next  = cmd_data;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cur_next    = st_raw;
                fs_next     = fs_w;
                fs5_next    = (FS_W+3)'({fs_w, 2'b00}) + (FS_W+3)'(fs_w);
                dv_next     = $signed({2'b00, item_reg.target_position})
                            - $signed({2'b00, st_raw.position});
                cd_sub_next = st_raw.countdown - $signed({2'b00, item_reg.elapsed});
                if (!in_range || !item_reg.mode)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                adv_next   = adv18[PER_W-1:0];
                state_next = (dv_reg == '0) ? S_FIN : S_GO;
            end
            S_GO:
            begin
                if (adv_reg == '0)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_load   = 1'b1;
                    ram_we     = in_range;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // clamp of the division result and signed period
    always_comb
    begin
        if (adv_reg == '0)
        begin
            mag = PERIOD_MAX;
        end
        else if (div_quo < DIVD_W'(PERIOD_MIN))
        begin
            mag = PERIOD_MIN;
        end
        else if (div_quo > DIVD_W'(PERIOD_MAX))
        begin
            mag = PERIOD_MAX;
        end
        else
        begin
            mag = div_quo[POS_W-1:0];
        end
        new_period = adv_reg[PER_W-1] ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
    end

    // one step of the addressed motor
    assign per_abs = cur_reg.step_period[PER_W-1] ? PER_W'(-cur_reg.step_period)
                                                  : PER_W'(cur_reg.step_period);
    assign per_fwd = !cur_reg.step_period[PER_W-1] && (cur_reg.step_period != '0);
    assign cd_le0  = cd_sub_reg[CD_W-1] || (cd_sub_reg == '0);
    assign pinc    = {1'b0, cur_reg.position} + FS_W'(1);
    assign fsm1    = fs_reg - FS_W'(1);

    always_comb
    begin
        if (per_fwd)
        begin
            stepped_pos = (pinc >= fs_reg) ? '0 : pinc[POS_W-1:0];
        end
        else if (cur_reg.position == '0)
        begin
            stepped_pos = fsm1[POS_W-1:0];
        end
        else
        begin
            stepped_pos = cur_reg.position - POS_W'(1);
        end
    end

    always_comb
    begin
        new_state        = cur_reg;
        rsp_w.step_pulse = 1'b0;
        rsp_w.direction  = 1'b0;
        rsp_w.motor_echo = item_reg.motor;
        rsp_w.position   = '0;
        rsp_w.moving     = 1'b0;
        if (item_reg.mode)
        begin
            new_state.target = item_reg.target_position;
            if (dv_reg != '0)
            begin
                new_state.step_period = new_period;
                new_state.countdown   = {3'b000, mag};
            end
            rsp_w.direction = !new_state.step_period[PER_W-1]
                           && (new_state.step_period != '0);
        end
        else if (cur_reg.step_period != '0)
        begin
            rsp_w.direction     = per_fwd;
            new_state.countdown = cd_sub_reg;
            if (cd_le0)
            begin
                rsp_w.step_pulse   = 1'b1;
                new_state.position = stepped_pos;
                if (cur_reg.target != stepped_pos)
                begin
                    new_state.countdown = {1'b0, per_abs};
                end
                else
                begin
                    new_state.step_period = '0;
                end
            end
        end
        rsp_w.position = new_state.position;
        rsp_w.moving   = (new_state.step_period != '0);
        if (!in_range)
        begin
            rsp_w.step_pulse = 1'b0;
            rsp_w.direction  = 1'b0;
            rsp_w.position   = '0;
            rsp_w.moving     = 1'b0;
        end
    end

    always_comb
    begin
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            vld_reg       <= '0;
            cont_mask_reg <= '0;
            for (int i = 0; i < REVS; i++)
            begin
                steps_rev_reg[i] <= REV_RESET;
            end
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (ram_we)
            begin
                vld_reg[addr] <= 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_STEPS_REV_ZERO:  steps_rev_reg[0] <= cfg_data;
                    CFG_STEPS_REV_ONE:   steps_rev_reg[1] <= cfg_data;
                    CFG_STEPS_REV_TWO:   steps_rev_reg[2] <= cfg_data;
                    CFG_STEPS_REV_THREE: steps_rev_reg[3] <= cfg_data;
                    CFG_CONTINUOUS_MASK: cont_mask_reg    <= cfg_data[MASK_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        cur_reg    <= cur_next;
        fs_reg     <= fs_next;
        fs5_reg    <= fs5_next;
        dv_reg     <= dv_next;
        cd_sub_reg <= cd_sub_next;
        adv_reg    <= adv_next;
        if (rsp_load)
        begin
            rsp_data_reg <= rsp_w;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for the timed stepper positioner: directed moves, random traffic
`timescale 1ns / 1ps

module testbench;
    import stp_pkg::*;

    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_MOVE = 1'b1;
    localparam int   CYCLE_LIMIT = 400000;
    localparam int   HOLD_CYCLES = 120;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cmd_valid;
    logic                 cmd_stall;
    cmd_item_t            cmd_data;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    rsp_item_t            rsp_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [REV_W-1:0]     cfg_data;

    // motor state and settings as the block should hold them
    int          cd_left[4];
    int          period_q[4];
    int          goal_pos[4];
    int          cur_pos[4];
    int          rev_cfg[4] = '{default: int'(REV_RESET)};
    logic [3:0]  cont_mask = '0;

    rsp_item_t   pending_reports[$];
    rsp_item_t   due;
    int          errors = 0;
    int          cycle_count = 0;
    bit          quiet = 1'b0;
    bit          hold_req = 1'b0;
    int          hold_left = 0;

    stepper_timed_positioner_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic int rev_span(input int m);
        return (rev_cfg[m] == 0) ? int'(REV_FULL) : rev_cfg[m];
    endfunction

    // applies one item to the motor state and returns the report it should produce
    function automatic rsp_item_t advance_motor(input cmd_item_t c);
        rsp_item_t r;
        int        m;
        int        fs;
        int        dv;
        int        mag;
        int        p;
        bit        fwd;
        r = '0;
        m = int'(c.motor);
        fs = rev_span(m);
        r.motor_echo = c.motor;
        if (c.mode == MODE_MOVE)
        begin
            dv = int'(c.target_position) - cur_pos[m];
            goal_pos[m] = int'(c.target_position);
            if (dv != 0)
            begin
                if (cont_mask[m])
                begin
                    // take the shorter way round past 5/6 of a turn
                    if (dv < 0 && -6 * dv > 5 * fs)
                        dv += fs;
                    else if (dv > 0 && 6 * dv > 5 * fs)
                        dv -= fs;
                end
                if (dv == 0)
                    mag = int'(PERIOD_MAX);
                else
                begin
                    mag = (int'(c.move_time) * 10) / ((dv < 0) ? -dv : dv);
                    if (mag < int'(PERIOD_MIN))
                        mag = int'(PERIOD_MIN);
                    if (mag > int'(PERIOD_MAX))
                        mag = int'(PERIOD_MAX);
                end
                period_q[m] = (dv < 0) ? -mag : mag;
                cd_left[m] = mag;
            end
            r.direction = period_q[m] > 0;
        end
        else if (period_q[m] != 0)
        begin
            fwd = period_q[m] > 0;
            r.direction = fwd;
            cd_left[m] -= int'(c.elapsed);
            if (cd_left[m] < 1)
            begin
                p = cur_pos[m];
                r.step_pulse = 1'b1;
                if (fwd)
                begin
                    p++;
                    if (p >= fs)
                        p = 0;
                end
                else
                    p = (p == 0) ? fs - 1 : p - 1;
                cur_pos[m] = p & 32'h7fff;
                if (goal_pos[m] != cur_pos[m])
                    cd_left[m] = (period_q[m] < 0) ? -period_q[m] : period_q[m];
                else
                    period_q[m] = 0;
            end
        end
        r.position = cur_pos[m][POS_W-1:0];
        r.moving = period_q[m] != 0;
        return r;
    endfunction

    function automatic cmd_item_t tick_item(input int m, input int el);
        cmd_item_t c;
        c.mode = MODE_TICK;
        c.motor = m[MOTOR_W-1:0];
        c.elapsed = el[TIME_W-1:0];
        c.target_position = POS_W'($urandom);
        c.move_time = TIME_W'($urandom);
        return c;
    endfunction

    function automatic cmd_item_t move_item(input int m, input int tgt, input int mt);
        cmd_item_t c;
        c.mode = MODE_MOVE;
        c.motor = m[MOTOR_W-1:0];
        c.elapsed = TIME_W'($urandom);
        c.target_position = tgt[POS_W-1:0];
        c.move_time = mt[TIME_W-1:0];
        return c;
    endfunction

    task automatic check_field(input string name, input logic [POS_W-1:0] want,
                               input logic [POS_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic send_cmd(input cmd_item_t c);
        int gap;
        if (!quiet && $urandom_range(99) < 31)
        begin
            gap = ($urandom_range(7) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
            cmd_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_valid = 1'b1;
        cmd_data = c;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        pending_reports.push_back(advance_motor(c));
        @(negedge clk);
    endtask

    task automatic drain_reports();
        cmd_valid = 1'b0;
        while (pending_reports.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REV_W-1:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_CONTINUOUS_MASK)
            cont_mask = val[MASK_W-1:0];
        else
            rev_cfg[idx[1:0]] = int'(val);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic apply_setup(input int r0, input int r1, input int r2, input int r3,
                               input logic [MASK_W-1:0] mask);
        drain_reports();
        write_reg(CFG_STEPS_REV_ZERO, r0[REV_W-1:0]);
        write_reg(CFG_STEPS_REV_ONE, r1[REV_W-1:0]);
        write_reg(CFG_STEPS_REV_TWO, r2[REV_W-1:0]);
        write_reg(CFG_STEPS_REV_THREE, r3[REV_W-1:0]);
        write_reg(CFG_CONTINUOUS_MASK, {(REV_W - MASK_W)'($urandom), mask});
    endtask

    task automatic test_idle_and_zero_distance();
        send_cmd(tick_item(0, 0));
        send_cmd(tick_item(3, 65535));
        send_cmd(move_item(1, 0, 0));
    endtask

    task automatic test_step_and_stop();
        // short move at the fastest period, then back at the slowest
        send_cmd(move_item(0, 2, 0));
        send_cmd(tick_item(0, 299));
        send_cmd(tick_item(0, 1));
        send_cmd(tick_item(0, 65535));
        send_cmd(move_item(0, 0, 65535));
        send_cmd(tick_item(0, 65535));
        send_cmd(tick_item(0, 65535));
    endtask

    task automatic test_revolution_extremes();
        apply_setup(1, 32767, 0, 3, 4'b1111);
        // one step per turn with a target that can never be reached
        send_cmd(move_item(0, 5, 7));
        send_cmd(tick_item(0, 300));
        send_cmd(tick_item(0, 65535));
        // full-turn distance collapses to zero on the short way
        send_cmd(move_item(1, 32767, 65535));
        send_cmd(tick_item(1, 65535));
        // register zero means a 32768-step turn, backward from zero wraps
        send_cmd(move_item(2, 32767, 1));
        send_cmd(tick_item(2, 300));
        send_cmd(move_item(3, 2, 20));
        send_cmd(tick_item(3, 65535));
    endtask

    task automatic test_random_traffic(input int count);
        int m;
        int tgt;
        int mt;
        int el;
        for (int i = 0; i < count; i++)
        begin
            m = $urandom_range(3);
            if ($urandom_range(99) < ((period_q[m] == 0) ? 60 : 12))
            begin
                tgt = ($urandom_range(6) == 0) ? $urandom_range(32767)
                                               : $urandom_range(rev_span(m) - 1);
                case ($urandom_range(4))
                    0:       mt = 0;
                    1, 2:    mt = $urandom_range(65535);
                    default: mt = $urandom_range(600);
                endcase
                send_cmd(move_item(m, tgt, mt));
            end
            else
            begin
                case ($urandom_range(4))
                    0:       el = 0;
                    1, 2:    el = $urandom_range(400);
                    default: el = $urandom_range(65535);
                endcase
                send_cmd(tick_item(m, el));
            end
        end
    endtask

    task automatic test_output_backpressure();
        drain_reports();
        hold_req = 1'b1;
        test_random_traffic(14);
    endtask

    // result side: random stalls, quiet stretches and one long hold
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_stall <= 1'b1;
        end
        else if (quiet)
            rsp_stall <= 1'b0;
        else
            rsp_stall <= ($urandom_range(99) < 31);
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_reports.size() == 0)
            begin
                $error("unexpected result transaction: %p", rsp_data);
                errors++;
            end
            else
            begin
                due = pending_reports.pop_front();
                check_field("step_pulse", POS_W'(due.step_pulse),
                            POS_W'(rsp_data.step_pulse));
                check_field("direction", POS_W'(due.direction),
                            POS_W'(rsp_data.direction));
                check_field("motor_echo", POS_W'(due.motor_echo),
                            POS_W'(rsp_data.motor_echo));
                check_field("position", due.position, rsp_data.position);
                check_field("moving", POS_W'(due.moving), POS_W'(rsp_data.moving));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        cmd_data = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_STEPS_REV_ZERO;
        cfg_data = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_idle_and_zero_distance();
        test_step_and_stop();
        test_revolution_extremes();

        apply_setup(8, 50, 200, 1, 4'b0101);
        test_random_traffic(110);
        test_output_backpressure();

        apply_setup($urandom_range(1, 64), $urandom_range(1, 64), $urandom_range(1, 64),
                    $urandom_range(1, 64), 4'($urandom));
        quiet = 1'b1;
        test_random_traffic(100);
        quiet = 1'b0;

        apply_setup(32767, 0, 2, $urandom_range(1, 20), 4'b1111);
        test_random_traffic(100);

        apply_setup($urandom_range(1, 400), $urandom_range(1, 400), $urandom_range(1, 400),
                    $urandom_range(1, 400), 4'($urandom));
        test_random_traffic(100);

        drain_reports();
        repeat (30) @(negedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ files.f @@
src/stp_pkg.sv
src/stp_ram.sv
src/stp_div.sv
src/stepper_timed_positioner_top.sv
tb/testbench.sv
